// ----- src/fcpa_pkg.sv -----
package fcpa_pkg;

  // Default pool size and register reset value.
  localparam int          CHUNKS_DEF      = 64;
  localparam logic [15:0] CHUNK_BYTES_RST = 16'd64;

  // Field widths of the two channels.
  localparam int OPCODE_W = 1;
  localparam int BYTES_W  = 16;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 7;
  localparam int USED_W   = 22;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_TOO_LARGE   = 2'd1,
    ST_EMPTY       = 2'd2,
    ST_DOUBLE_FREE = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [BYTES_W-1:0] request_bytes;
    logic [BYTES_W-1:0] request_alignment;
    logic [INDEX_W-1:0] chunk_index;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] granted_index;
    logic [FREE_W-1:0]  free_chunks;
    logic [USED_W-1:0]  bytes_in_use;
  } out_item_t;

  // Commands from the request logic to the free stack.
  typedef struct packed {
    logic pop;
    logic push;
  } stk_cmd_t;

endpackage

// ----- src/fcpa_ram.sv -----
module fcpa_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/fcpa_stack.sv -----
module fcpa_stack #(
  parameter int  CHUNKS = fcpa_pkg::CHUNKS_DEF,
  localparam int IW     = $clog2(CHUNKS),
  localparam int CW     = $clog2(CHUNKS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fcpa_pkg::stk_cmd_t cmd,
  input  logic [IW-1:0]      push_idx,
  output logic [CW-1:0]      count,
  output logic [CW-1:0]      count_nxt,
  output logic [IW-1:0]      top
);

  logic [CW-1:0] count_r;
  logic [CW-1:0] min_r;
  logic [CW-1:0] min_nxt;
  logic [CW-1:0] pos_last;
  logic [CW-1:0] rd_full;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] ram_q;
  logic          fwd_r;
  logic [IW-1:0] fwd_val_r;
  logic          ident_r;
  logic [IW-1:0] ident_val_r;

  // Count and low-water mark. Positions below the lowest count ever reached
  // were never popped, so they still hold their reset contents (their own
  // position); everything at or above it has been rewritten by a push.
  always_comb begin
    pos_last  = count_r - CW'(1);
    count_nxt = count_r + CW'(cmd.push) - CW'(cmd.pop);
    min_nxt   = (cmd.pop && (pos_last < min_r)) ? pos_last : min_r;
    rd_full   = (count_nxt == '0) ? '0 : count_nxt - CW'(1);
    rd_addr   = rd_full[IW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= CW'(CHUNKS);
      min_r       <= CW'(CHUNKS);
      fwd_r       <= 1'b0;
      ident_r     <= 1'b1;
      ident_val_r <= IW'(CHUNKS - 1);
    end else begin
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      fwd_r       <= cmd.push;
      ident_r     <= (rd_full < min_nxt);
      ident_val_r <= rd_addr;
    end
  end

  // A push always lands on the next top of stack, so it is forwarded.
  always_ff @(posedge clk) begin
    fwd_val_r <= push_idx;
  end

  fcpa_ram #(
    .WIDTH (IW),
    .DEPTH (CHUNKS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (count_r[IW-1:0]),
    .wdata (push_idx),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Top of stack for the current state, valid in every cycle.
  always_comb begin
    if (fwd_r) begin
      top = fwd_val_r;
    end else if (ident_r) begin
      top = ident_val_r;
    end else begin
      top = ram_q;
    end
  end

  assign count = count_r;

endmodule

// ----- src/fixed_chunk_pool_allocator_core.sv -----
// Channel  Direction  Payload                Handshake
// in_      input      fcpa_pkg::in_item_t    in_valid / in_ready
// out_     output     fcpa_pkg::out_item_t   out_valid / out_ready
// cfg_     input      chunk_bytes, 16 bits   cfg_we, no wait
//
// One request per cycle while the result register is not blocked; a request
// passes the input register and then the result register before its result
// can be transferred out. The free stack top is kept valid every cycle by a
// registered read plus forwarding of the last push. The allocation mark and
// the recorded size of a request are read as it is transferred in.
// Synchronous active-low reset; the stack needs no clearing pass after it.
// A stalled result register holds the request stage, and in_ready falls only
// while both are full and out_ready is low.
module fixed_chunk_pool_allocator_core #(
  parameter int  CHUNKS = fcpa_pkg::CHUNKS_DEF,
  localparam int IW     = $clog2(CHUNKS),
  localparam int CW     = $clog2(CHUNKS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  fcpa_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output fcpa_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);

  localparam int XW = IW + fcpa_pkg::INDEX_W;

  logic                          in_fire;
  logic                          proc_fire;
  logic                          stg_valid_r;
  fcpa_pkg::in_item_t            stg_item_r;
  logic                          out_valid_r;
  fcpa_pkg::out_item_t           out_item_r;
  fcpa_pkg::out_item_t           res;
  logic [15:0]                   chunk_bytes_r;
  logic [fcpa_pkg::USED_W-1:0]   used_r;
  logic [fcpa_pkg::USED_W-1:0]   used_nxt;
  logic [CHUNKS-1:0]             mark_r;
  logic [CHUNKS-1:0]             mark_nxt;
  logic                          mark_q_r;

  logic [XW-1:0]                 idx_ext;
  logic [XW-1:0]                 in_idx_ext;
  logic                          in_range;
  logic                          mark_hit;
  logic                          is_alloc;
  logic                          too_large;
  logic                          empty;
  logic                          alloc_ok;
  logic                          free_ok;

  fcpa_pkg::stk_cmd_t            stk_cmd;
  logic [CW-1:0]                 stk_count;
  logic [CW-1:0]                 stk_count_nxt;
  logic [IW-1:0]                 stk_top;
  logic [XW-1:0]                 top_ext;
  logic [CW+fcpa_pkg::FREE_W-1:0] cnt_ext;

  logic [IW-1:0]                 rs_raddr;
  logic                          rs_we;
  logic [15:0]                   rs_q;
  logic                          rs_fwd_r;
  logic [15:0]                   rs_fwd_data_r;
  logic [15:0]                   rsize;

  // Handshakes: the request stage moves on whenever the result register
  // is empty or being emptied.
  assign proc_fire = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !stg_valid_r || proc_fire;
  assign in_fire   = in_valid && in_ready;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_bytes_r <= fcpa_pkg::CHUNK_BYTES_RST;
    end else if (cfg_we) begin
      chunk_bytes_r <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_item_r <= in_item;
    end
  end

  // Index handling at the internal index width.
  assign idx_ext    = {{IW{1'b0}}, stg_item_r.chunk_index};
  assign in_idx_ext = {{IW{1'b0}}, in_item.chunk_index};
  assign in_range   = idx_ext < XW'(CHUNKS);
  assign mark_hit   = in_range && mark_q_r;

  // Request decision.
  always_comb begin
    is_alloc  = (stg_item_r.opcode == fcpa_pkg::OP_ALLOC);
    too_large = (stg_item_r.request_bytes > chunk_bytes_r) ||
                (stg_item_r.request_alignment > chunk_bytes_r);
    empty     = (stk_count == '0);
    alloc_ok  = is_alloc && !too_large && !empty;
    free_ok   = !is_alloc && mark_hit && (stk_count < CW'(CHUNKS));
  end

  assign stk_cmd.pop  = proc_fire && alloc_ok;
  assign stk_cmd.push = proc_fire && free_ok;

  fcpa_stack #(
    .CHUNKS (CHUNKS)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (stk_cmd),
    .push_idx  (idx_ext[IW-1:0]),
    .count     (stk_count),
    .count_nxt (stk_count_nxt),
    .top       (stk_top)
  );

  // Recorded sizes. The read is issued as the request is transferred in,
  // and a write to the same entry at that edge is forwarded.
  assign rs_raddr = in_fire ? in_idx_ext[IW-1:0] : idx_ext[IW-1:0];
  assign rs_we    = proc_fire && alloc_ok;

  fcpa_ram #(
    .WIDTH (16),
    .DEPTH (CHUNKS)
  ) u_size_ram (
    .clk   (clk),
    .we    (rs_we),
    .waddr (stk_top),
    .wdata (stg_item_r.request_bytes),
    .raddr (rs_raddr),
    .rdata (rs_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_fwd_r <= 1'b0;
    end else begin
      rs_fwd_r <= rs_we && (stk_top == rs_raddr);
    end
  end

  always_ff @(posedge clk) begin
    rs_fwd_data_r <= stg_item_r.request_bytes;
  end

  assign rsize = rs_fwd_r ? rs_fwd_data_r : rs_q;

  // Allocation marks. The mark of a request is read at the same address and
  // edge as its recorded size, with that edge's update already applied.
  always_comb begin
    mark_nxt = mark_r;
    if (proc_fire) begin
      if (alloc_ok) begin
        mark_nxt[stk_top] = 1'b1;
      end else if (free_ok) begin
        mark_nxt[idx_ext[IW-1:0]] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= '0;
    end else begin
      mark_r <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mark_q_r <= mark_nxt[rs_raddr];
  end

  // Byte total in use, wrapping at its width.
  always_comb begin
    if (alloc_ok) begin
      used_nxt = used_r + {6'd0, stg_item_r.request_bytes};
    end else if (free_ok) begin
      used_nxt = used_r - {6'd0, rsize};
    end else begin
      used_nxt = used_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (proc_fire) begin
      used_r <= used_nxt;
    end
  end

  // Result fields.
  assign top_ext = {{fcpa_pkg::INDEX_W{1'b0}}, stk_top};
  assign cnt_ext = {{fcpa_pkg::FREE_W{1'b0}}, stk_count_nxt};

  always_comb begin
    if (is_alloc) begin
      if (too_large) begin
        res.status = fcpa_pkg::ST_TOO_LARGE;
      end else if (empty) begin
        res.status = fcpa_pkg::ST_EMPTY;
      end else begin
        res.status = fcpa_pkg::ST_OK;
      end
    end else begin
      res.status = free_ok ? fcpa_pkg::ST_OK : fcpa_pkg::ST_DOUBLE_FREE;
    end
    res.granted_index = alloc_ok ? top_ext[fcpa_pkg::INDEX_W-1:0] : '0;
    res.free_chunks   = cnt_ext[fcpa_pkg::FREE_W-1:0];
    res.bytes_in_use  = used_nxt;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Every chunk is either on the free stack or marked allocated.
  a_pool_conserved: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(mark_r) + int'(stk_count)) == CHUNKS)
    else $error("free count and allocation marks disagree");

  // A granted chunk is marked allocated right after the grant.
  a_grant_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && alloc_ok) |=> mark_r[$past(stk_top)])
    else $error("granted chunk not marked allocated");

  // A refused request never changes the free count.
  a_refuse_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_fire && !alloc_ok && !free_ok) |=> (stk_count == $past(stk_count)))
    else $error("refused request changed the free count");

  // The input side stalls only when both registers are full and blocked.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (stg_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked result");

endmodule

// ----- dv/tb_fixed_chunk_pool_allocator_core.sv -----
`timescale 1ns / 1ps

module tb_fixed_chunk_pool_allocator_core;

  localparam int CHUNKS      = fcpa_pkg::CHUNKS_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 80;

  // One row of the directed stimulus; want is used only when typed is set.
  typedef struct {
    fcpa_pkg::opcode_t   op;
    logic [15:0]         nbytes;
    logic [15:0]         align;
    logic [5:0]          idx;
    bit                  typed;
    fcpa_pkg::out_item_t want;
  } directed_row_t;

  // One random phase: chunk size, share of allocations, length, setup.
  typedef struct {
    logic [15:0] limit;
    int          alloc_pct;
    int          items;
    bit          reprogram;
    bit          fill;
  } pool_phase_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  fcpa_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  fcpa_pkg::out_item_t out_item;
  logic                cfg_we;
  logic [15:0]         cfg_wdata;

  // Shadow copy of the allocator state.
  logic [5:0]  free_stack_shadow [CHUNKS];
  int          free_depth;
  bit          chunk_busy [CHUNKS];
  logic [15:0] chunk_size [CHUNKS];
  logic [21:0] bytes_used;
  logic [15:0] chunk_limit;

  fcpa_pkg::out_item_t pending_results [$];
  int                  error_count;
  int                  results_seen;
  int                  cycle_count;
  bit                  quiet;

  directed_row_t stim_rows [16] = '{
    '{fcpa_pkg::OP_ALLOC, 16'd64,   16'd64,   6'd0,  1'b1,
      '{fcpa_pkg::ST_OK,          6'd63, 7'd63, 22'd64}},
    '{fcpa_pkg::OP_ALLOC, 16'd65,   16'd0,    6'd0,  1'b1,
      '{fcpa_pkg::ST_TOO_LARGE,   6'd0,  7'd63, 22'd64}},
    '{fcpa_pkg::OP_ALLOC, 16'd0,    16'd65,   6'd0,  1'b1,
      '{fcpa_pkg::ST_TOO_LARGE,   6'd0,  7'd63, 22'd64}},
    '{fcpa_pkg::OP_ALLOC, 16'hFFFF, 16'hFFFF, 6'd0,  1'b1,
      '{fcpa_pkg::ST_TOO_LARGE,   6'd0,  7'd63, 22'd64}},
    '{fcpa_pkg::OP_FREE,  16'd0,    16'd0,    6'd0,  1'b1,
      '{fcpa_pkg::ST_DOUBLE_FREE, 6'd0,  7'd63, 22'd64}},
    '{fcpa_pkg::OP_ALLOC, 16'd0,    16'd0,    6'd0,  1'b1,
      '{fcpa_pkg::ST_OK,          6'd62, 7'd62, 22'd64}},
    '{fcpa_pkg::OP_FREE,  16'd0,    16'd0,    6'd63, 1'b1,
      '{fcpa_pkg::ST_OK,          6'd0,  7'd63, 22'd0}},
    '{fcpa_pkg::OP_FREE,  16'd0,    16'd0,    6'd63, 1'b1,
      '{fcpa_pkg::ST_DOUBLE_FREE, 6'd0,  7'd63, 22'd0}},
    '{fcpa_pkg::OP_ALLOC, 16'd1,    16'd1,    6'd0,  1'b1,
      '{fcpa_pkg::ST_OK,          6'd63, 7'd62, 22'd1}},
    '{fcpa_pkg::OP_FREE,  16'd0,    16'd0,    6'd62, 1'b1,
      '{fcpa_pkg::ST_OK,          6'd0,  7'd63, 22'd1}},
    '{fcpa_pkg::OP_ALLOC, 16'd32,   16'd16,   6'd0,  1'b1,
      '{fcpa_pkg::ST_OK,          6'd62, 7'd62, 22'd33}},
    '{fcpa_pkg::OP_FREE,  16'hFFFF, 16'hFFFF, 6'd63, 1'b1,
      '{fcpa_pkg::ST_OK,          6'd0,  7'd63, 22'd32}},
    '{fcpa_pkg::OP_ALLOC, 16'h8000, 16'h0001, 6'h3F, 1'b0, '0},
    '{fcpa_pkg::OP_FREE,  16'h5555, 16'hAAAA, 6'h2A, 1'b0, '0},
    '{fcpa_pkg::OP_FREE,  16'd0,    16'd0,    6'd62, 1'b1,
      '{fcpa_pkg::ST_OK,          6'd0,  7'd64, 22'd0}},
    '{fcpa_pkg::OP_FREE,  16'd0,    16'd0,    6'h3F, 1'b1,
      '{fcpa_pkg::ST_DOUBLE_FREE, 6'd0,  7'd64, 22'd0}}
  };

  pool_phase_t phase_plan [7] = '{
    '{16'd64,    80, 250, 1'b0, 1'b1},
    '{16'd1,     30, 200, 1'b1, 1'b0},
    '{16'd0,     70, 150, 1'b1, 1'b0},
    '{16'hFFFF,  85, 150, 1'b1, 1'b1},
    '{16'd1000,  20, 250, 1'b1, 1'b0},
    '{16'd500,   60, 200, 1'b1, 1'b0},
    '{16'd64,    50, 200, 1'b1, 1'b0}
  };

  fixed_chunk_pool_allocator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Return the shadow state to the allocator's reset contents.
  task automatic reset_pool_shadow();
    for (int k = 0; k < CHUNKS; k++) begin
      free_stack_shadow[k] = 6'(k);
      chunk_busy[k]        = 1'b0;
      chunk_size[k]        = '0;
    end
    free_depth  = CHUNKS;
    bytes_used  = '0;
    chunk_limit = fcpa_pkg::CHUNK_BYTES_RST;
  endtask

  // Apply one request to the shadow state and return the result it gives.
  function automatic fcpa_pkg::out_item_t predict_request(input fcpa_pkg::in_item_t req);
    fcpa_pkg::out_item_t res;
    logic [5:0] slot;
    res = '0;
    res.status = fcpa_pkg::ST_OK;
    if (req.opcode == fcpa_pkg::OP_ALLOC) begin
      if (req.request_bytes > chunk_limit || req.request_alignment > chunk_limit) begin
        res.status = fcpa_pkg::ST_TOO_LARGE;
      end else if (free_depth == 0) begin
        res.status = fcpa_pkg::ST_EMPTY;
      end else begin
        free_depth--;
        slot = free_stack_shadow[free_depth];
        chunk_busy[slot] = 1'b1;
        chunk_size[slot] = req.request_bytes;
        bytes_used = bytes_used + 22'(req.request_bytes);
        res.granted_index = slot;
      end
    end else begin
      if (!chunk_busy[req.chunk_index] || free_depth >= CHUNKS) begin
        res.status = fcpa_pkg::ST_DOUBLE_FREE;
      end else begin
        chunk_busy[req.chunk_index] = 1'b0;
        bytes_used = bytes_used - 22'(chunk_size[req.chunk_index]);
        free_stack_shadow[free_depth] = req.chunk_index;
        free_depth++;
      end
    end
    res.free_chunks  = 7'(free_depth);
    res.bytes_in_use = bytes_used;
    return res;
  endfunction

  // Sizes cluster around the configured limit: zero, at it, just over it, up to it, or any 16-bit value.
  function automatic logic [15:0] pick_size();
    logic [16:0] above;
    above = {1'b0, chunk_limit} + 17'd1;
    case ($urandom_range(0, 5))
      0: return '0;
      1: return chunk_limit;
      2: return above[16] ? chunk_limit : above[15:0];
      5: return 16'($urandom);
      default: return 16'($urandom_range(0, chunk_limit));
    endcase
  endfunction

  // Random request; frees mostly name a chunk that is currently allocated.
  function automatic fcpa_pkg::in_item_t make_request(input int alloc_pct);
    fcpa_pkg::in_item_t req;
    int start;
    req.request_bytes     = pick_size();
    req.request_alignment = pick_size();
    req.chunk_index       = 6'($urandom);
    if ($urandom_range(0, 99) < alloc_pct) begin
      req.opcode = fcpa_pkg::OP_ALLOC;
    end else begin
      req.opcode = fcpa_pkg::OP_FREE;
      if ($urandom_range(0, 99) < 85) begin
        start = $urandom_range(0, CHUNKS - 1);
        for (int k = 0; k < CHUNKS; k++) begin
          if (chunk_busy[(start + k) % CHUNKS]) begin
            req.chunk_index = 6'((start + k) % CHUNKS);
            break;
          end
        end
      end
    end
    return req;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("tb: mismatch on %s: got %0d, want %0d", what, got, want);
    error_count++;
  endtask

  // Offer one request, wait for its transfer and queue the expected result.
  task automatic offer_request(input fcpa_pkg::in_item_t req, input bit typed,
                               input fcpa_pkg::out_item_t want);
    fcpa_pkg::out_item_t predicted;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_request(req);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic send_alloc(input logic [15:0] nbytes, input logic [15:0] align);
    fcpa_pkg::in_item_t req;
    req.opcode            = fcpa_pkg::OP_ALLOC;
    req.request_bytes     = nbytes;
    req.request_alignment = align;
    req.chunk_index       = 6'($urandom);
    offer_request(req, 1'b0, '0);
  endtask

  // Change the chunk size once every outstanding result has come back.
  task automatic program_chunk_bytes(input logic [15:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    chunk_limit = value;
  endtask

  // Result side: random stalls, one long hold to back up the input.
  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!quiet && !hold_done && results_seen >= 200) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin : check_results
    fcpa_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_item.status, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status)
          report_mismatch("status", out_item.status, want.status);
        if (out_item.granted_index !== want.granted_index)
          report_mismatch("granted_index", out_item.granted_index, want.granted_index);
        if (out_item.free_chunks !== want.free_chunks)
          report_mismatch("free_chunks", out_item.free_chunks, want.free_chunks);
        if (out_item.bytes_in_use !== want.bytes_in_use)
          report_mismatch("bytes_in_use", out_item.bytes_in_use, want.bytes_in_use);
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    fcpa_pkg::in_item_t req;
    pool_phase_t plan;
    error_count  = 0;
    results_seen = 0;
    cycle_count  = 0;
    quiet        = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    phase_plan[5].limit = 16'($urandom_range(100, 9000));
    reset_pool_shadow();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: limits, priority of checks, LIFO order, double frees.
    foreach (stim_rows[r]) begin
      req.opcode            = stim_rows[r].op;
      req.request_bytes     = stim_rows[r].nbytes;
      req.request_alignment = stim_rows[r].align;
      req.chunk_index       = stim_rows[r].idx;
      offer_request(req, stim_rows[r].typed, stim_rows[r].want);
    end

    // Random phases, each under its own chunk size.
    foreach (phase_plan[p]) begin
      plan = phase_plan[p];
      if (plan.reprogram) program_chunk_bytes(plan.limit);
      if (p == $size(phase_plan) - 1) quiet = 1'b1;
      // Empty the pool at full size, then hit it while empty, too large as well.
      if (plan.fill) begin
        while (free_depth != 0) send_alloc(chunk_limit, chunk_limit);
        send_alloc(chunk_limit, 16'd0);
        if (chunk_limit != 16'hFFFF) send_alloc(chunk_limit + 16'd1, 16'd0);
      end
      repeat (plan.items) offer_request(make_request(plan.alloc_pct), 1'b0, '0);
    end

    // Drain and let the pipeline settle.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
